// File: src/b64c_pkg.sv
// Shared types, constants and alphabet functions of the base64 stream codec.
package b64c_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
    logic       bad_length;
  } out_word_t;

  // One finished group, handed from the front to the back.
  typedef struct packed {
    logic        dec;
    logic [23:0] bits;
    logic [2:0]  cnt;
    logic        last;
    logic        bad;
    logic [1:0]  epad;
  } job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] h);
    logic [7:0] c;
    if (h < 6'd26) begin
      c = 8'(8'd65 + {2'b00, h});
    end else if (h < 6'd52) begin
      c = 8'(8'd97 + {2'b00, h} - 8'd26);
    end else if (h < 6'd62) begin
      c = 8'(8'd48 + {2'b00, h} - 8'd52);
    end else if (h == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [5:0] s;
    if (c >= 8'd65 && c <= 8'd90) begin
      s = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s = 6'(c - 8'd97 + 8'd26);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s = 6'(c - 8'd48 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      s = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s = 6'd63;
    end else begin
      s = 6'd0;
    end
    return s;
  endfunction

endpackage

// File: src/b64c_front.sv
// Front end: mode register, group gathering and job building.
module b64c_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  input  logic              q_full,
  input  b64c_pkg::in_word_t in_word,
  output logic              in_stall,
  output logic              push,
  output b64c_pkg::job_t    push_job
);
  import b64c_pkg::*;

  logic        mode_r, mode_nxt;
  logic [23:0] bits_r, bits_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic        accept;
  logic [2:0]  n;
  logic [23:0] bits_new;
  logic [1:0]  pad_new;
  logic [2:0]  limit;
  logic [7:0]  b;
  logic [5:0]  sx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_word.data_in;
  assign sx       = char_to_sextet(b);
  assign n        = {1'b0, phase_r} + 3'd1;

  always_comb begin
    bits_new = bits_r;
    pad_new  = pad_r;
    if (mode_r == MODE_ENCODE) begin
      case (phase_r)
        2'd0:    bits_new = bits_r | {b, 16'h0000};
        2'd1:    bits_new = bits_r | {8'h00, b, 8'h00};
        default: bits_new = bits_r | {16'h0000, b};
      endcase
    end else begin
      if (b == CHAR_PAD) begin
        if (phase_r == 2'd2) begin
          pad_new = 2'd2;
        end else if (phase_r == 2'd3 && pad_r == 2'd0) begin
          pad_new = 2'd1;
        end
      end
      case (phase_r)
        2'd0:    bits_new = bits_r | {sx, 18'h00000};
        2'd1:    bits_new = bits_r | {6'h00, sx, 12'h000};
        2'd2:    bits_new = bits_r | {12'h000, sx, 6'h00};
        default: bits_new = bits_r | {18'h00000, sx};
      endcase
    end
  end

  assign limit = 3'd3 - {1'b0, pad_new};

  always_comb begin
    push          = 1'b0;
    push_job      = '0;
    push_job.dec  = mode_r;
    push_job.bits = bits_new;
    push_job.last = in_word.last_in;
    if (mode_r == MODE_ENCODE) begin
      push_job.cnt = 3'd4;
      if (n == 3'd3) begin
        push = accept;
      end else if (in_word.last_in) begin
        push          = accept;
        push_job.epad = (n == 3'd2) ? 2'd1 : 2'd2;
      end
    end else begin
      if (n == 3'd4) begin
        push         = accept;
        push_job.cnt = limit;
      end else if (in_word.last_in) begin
        push = accept;
        if (n == 3'd1) begin
          // A lone trailing character gives a single error result.
          push_job.cnt = 3'd1;
          push_job.bad = 1'b1;
        end else begin
          push_job.cnt = (n - 3'd1 > limit) ? limit : n - 3'd1;
        end
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    bits_nxt  = bits_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    if (cfg_we) begin
      mode_nxt  = cfg_wdata;
      bits_nxt  = '0;
      phase_nxt = '0;
      pad_nxt   = '0;
    end else if (accept) begin
      if (push) begin
        bits_nxt  = '0;
        phase_nxt = '0;
        pad_nxt   = '0;
      end else begin
        bits_nxt  = bits_new;
        phase_nxt = n[1:0];
        pad_nxt   = pad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      bits_r  <= '0;
      phase_r <= '0;
      pad_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      bits_r  <= bits_nxt;
      phase_r <= phase_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// File: src/b64c_queue.sv
// Short job queue between the front end and the back end.
module b64c_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64c_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output b64c_pkg::job_t head_job
);
  import b64c_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: src/b64c_back.sv
// Back end: walks each queued job and drives one result word per cycle while out_stall is low.
module b64c_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  b64c_pkg::job_t     head_job,
  input  logic               out_stall,
  output logic               pop,
  output logic               out_valid,
  output b64c_pkg::out_word_t out_word
);
  import b64c_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r;
  out_word_t  res;
  logic       load;
  logic       final_res;
  logic [5:0] sext;
  logic [7:0] byte_sel;
  logic       pad_hit;

  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign final_res = ({1'b0, idx_r} == head_job.cnt - 3'd1);
  assign pop       = load && final_res;

  always_comb begin
    case (idx_r)
      2'd0:    sext = head_job.bits[23:18];
      2'd1:    sext = head_job.bits[17:12];
      2'd2:    sext = head_job.bits[11:6];
      default: sext = head_job.bits[5:0];
    endcase
    case (idx_r)
      2'd0:    byte_sel = head_job.bits[23:16];
      2'd1:    byte_sel = head_job.bits[15:8];
      default: byte_sel = head_job.bits[7:0];
    endcase
  end

  assign pad_hit = (head_job.epad == 2'd2 && idx_r >= 2'd2) ||
                   (head_job.epad == 2'd1 && idx_r == 2'd3);

  always_comb begin
    res.bad_length = head_job.bad;
    res.last_out   = head_job.last && final_res;
    if (head_job.bad) begin
      res.data_out = 8'h00;
    end else if (head_job.dec == MODE_DECODE) begin
      res.data_out = byte_sel;
    end else begin
      res.data_out = pad_hit ? CHAR_PAD : sextet_to_char(sext);
    end
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = final_res ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // The result index never runs past the length of the job at the head.
  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head_job.cnt))
    else $error("result index beyond job length");

  // A queued job always carries at least one result.
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head_job.cnt != 3'd0))
    else $error("empty job in queue");

  // The error result always closes its message.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.bad_length |-> out_word_r.last_out)
    else $error("bad_length result without last_out");

  // An index left mid-job means the job is still queued.
  a_idx_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> head_valid)
    else $error("result index set with no job queued");

endmodule

// File: src/base64_stream_codec.sv
// Top level of the streaming base64 codec: front end, job queue and back end.
// The block encodes bytes to standard base64 text (mode 0) or decodes text to
// bytes (mode 1); writing the mode register also drops any half-gathered
// group. An input word is taken every cycle while the two-entry job queue has
// room, and the back end delivers one result word per cycle through its
// output register while out_stall is low, so the single result port sets the
// rate. The word that completes a group is written into the job queue, and its
// first result then leaves through the back end's output register. Characters
// outside the alphabet decode as zero, and a message that ends on a lone
// character yields one zero result with bad_length set. There is no clearing
// pass after reset.
module base64_stream_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64c_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output b64c_pkg::out_word_t out_word
);
  import b64c_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic head_valid;
  job_t push_job;
  job_t head_job;

  b64c_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .q_full   (q_full),
    .in_word  (in_word),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job)
  );

  b64c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
